// ----- rtl/dhbd_pkg.sv -----
// Shared types, constants and the exponent constant table for the box decoder.
// Used by dhbd_ctrl, dhbd_datapath and detection_head_box_decode.
`timescale 1ns / 1ps

package dhbd_pkg;

  localparam int CLASS_COUNT = 80;
  localparam int SIGMOID_TABLE_BITS = 10;
  localparam int SIG_SHIFT = 16 - SIGMOID_TABLE_BITS;

  localparam logic [7:0] CLASS_LIMIT = 8'(CLASS_COUNT);
  localparam logic [7:0] POS_OBJECT = 8'd4;
  localparam logic [7:0] POS_CLASS = 8'd5;
  localparam logic [7:0] POS_MAX = 8'd255;

  localparam logic [4:0] EXP_LAST = 5'd14;
  localparam logic [4:0] DIV_LAST = 5'd16;

  localparam logic [7:0] CFG_OBJECT_THRESHOLD = 8'd0;
  localparam logic [7:0] CFG_CLASS_THRESHOLD = 8'd1;
  localparam logic [7:0] CFG_SCALE_X = 8'd2;
  localparam logic [7:0] CFG_SCALE_Y = 8'd3;

  typedef struct packed {
    logic signed [15:0] logit;
    logic [7:0] cell_x;
    logic [7:0] cell_y;
    logic [2:0] stride_log2;
    logic [11:0] anchor_width;
    logic [11:0] anchor_height;
    logic last_of_cell;
  } item_t;

  typedef struct packed {
    logic signed [15:0] box_left;
    logic signed [15:0] box_top;
    logic [15:0] box_width;
    logic [15:0] box_height;
    logic [7:0] class_index;
    logic [15:0] confidence;
  } box_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECIDE,
    S_EXP,
    S_DIV_INIT,
    S_DIV,
    S_SIG_END,
    S_BOX1,
    S_BOX2,
    S_BOX3,
    S_BOX4,
    S_OUT
  } state_t;

  typedef struct packed {
    logic accept;
    logic sig_start;
    logic sig_sel_best;
    logic exp_step;
    logic div_start;
    logic div_step;
    logic write_elem;
    logic write_conf;
    logic box1;
    logic box2;
    logic box3;
    logic box4;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic needs_sig;
    logic last;
    logic obj_pass;
    logic conf_pass;
    logic exp_done;
    logic div_done;
    logic out_free;
  } stat_t;

  // e^-(2^b/256) in Q32.
  function automatic logic [31:0] exp_const(input logic [3:0] b);
    logic [31:0] c;
    unique case (b)
      4'd0: c = 32'd4278222805;
      4'd1: c = 32'd4261543592;
      4'd2: c = 32'd4228380001;
      4'd3: c = 32'd4162825044;
      4'd4: c = 32'd4034748382;
      4'd5: c = 32'd3790295336;
      4'd6: c = 32'd3344923894;
      4'd7: c = 32'd2605029343;
      4'd8: c = 32'd1580030169;
      4'd9: c = 32'd581260640;
      4'd10: c = 32'd78665070;
      4'd11: c = 32'd1440802;
      4'd12: c = 32'd483;
      default: c = 32'd0;
    endcase
    return c;
  endfunction

endpackage

// ----- rtl/dhbd_ctrl.sv -----
// Controller state machine of the box decoder.
// Depends on dhbd_pkg; drives the datapath through cmd_t and reads stat_t.
`timescale 1ns / 1ps

module dhbd_ctrl (
  input  logic clk,
  input  logic rst,
  input  logic item_valid,
  output logic item_stall,
  input  dhbd_pkg::stat_t stat,
  output dhbd_pkg::cmd_t cmd
);

  dhbd_pkg::state_t state, state_next;
  logic for_conf, for_conf_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dhbd_pkg::S_IDLE;
      for_conf <= 1'b0;
    end else begin
      state <= state_next;
      for_conf <= for_conf_next;
    end
  end

  always_comb begin
    state_next = state;
    for_conf_next = for_conf;
    cmd = '0;
    item_stall = 1'b1;
    unique case (state)
      dhbd_pkg::S_IDLE: begin
        item_stall = 1'b0;
        if (item_valid) begin
          cmd.accept = 1'b1;
          state_next = dhbd_pkg::S_DECIDE;
        end
      end
      dhbd_pkg::S_DECIDE: begin
        if (stat.needs_sig) begin
          cmd.sig_start = 1'b1;
          for_conf_next = 1'b0;
          state_next = dhbd_pkg::S_EXP;
        end else if (stat.last && stat.obj_pass) begin
          cmd.sig_start = 1'b1;
          cmd.sig_sel_best = 1'b1;
          for_conf_next = 1'b1;
          state_next = dhbd_pkg::S_EXP;
        end else begin
          state_next = dhbd_pkg::S_IDLE;
        end
      end
      dhbd_pkg::S_EXP: begin
        cmd.exp_step = 1'b1;
        if (stat.exp_done) state_next = dhbd_pkg::S_DIV_INIT;
      end
      dhbd_pkg::S_DIV_INIT: begin
        cmd.div_start = 1'b1;
        state_next = dhbd_pkg::S_DIV;
      end
      dhbd_pkg::S_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_done) state_next = dhbd_pkg::S_SIG_END;
      end
      dhbd_pkg::S_SIG_END: begin
        if (!for_conf) begin
          cmd.write_elem = 1'b1;
          state_next = dhbd_pkg::S_IDLE;
        end else if (stat.conf_pass) begin
          cmd.write_conf = 1'b1;
          state_next = dhbd_pkg::S_BOX1;
        end else begin
          state_next = dhbd_pkg::S_IDLE;
        end
      end
      dhbd_pkg::S_BOX1: begin
        cmd.box1 = 1'b1;
        state_next = dhbd_pkg::S_BOX2;
      end
      dhbd_pkg::S_BOX2: begin
        cmd.box2 = 1'b1;
        state_next = dhbd_pkg::S_BOX3;
      end
      dhbd_pkg::S_BOX3: begin
        cmd.box3 = 1'b1;
        state_next = dhbd_pkg::S_BOX4;
      end
      dhbd_pkg::S_BOX4: begin
        cmd.box4 = 1'b1;
        state_next = dhbd_pkg::S_OUT;
      end
      dhbd_pkg::S_OUT: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_next = dhbd_pkg::S_IDLE;
        end
      end
      default: state_next = dhbd_pkg::S_IDLE;
    endcase
  end

endmodule

// ----- rtl/dhbd_datapath.sv -----
// Datapath of the box decoder: cell state, sigmoid unit, box arithmetic and result register.
// Depends on dhbd_pkg; steered by dhbd_ctrl.
`timescale 1ns / 1ps

module dhbd_datapath (
  input  logic clk,
  input  logic rst,
  input  dhbd_pkg::item_t item,
  input  logic cfg_we,
  input  logic [7:0] cfg_index,
  input  logic [15:0] cfg_data,
  input  dhbd_pkg::cmd_t cmd,
  output dhbd_pkg::stat_t stat,
  output logic box_valid,
  input  logic box_stall,
  output dhbd_pkg::box_t box
);

  logic [15:0] object_threshold, class_threshold, scale_x, scale_y;
  logic [7:0] element_count;
  dhbd_pkg::item_t item_r;
  logic [7:0] pos;
  logic [15:0] box_terms [4];
  logic [15:0] object_prob;
  logic signed [15:0] best_class_logit;
  logic [7:0] best_class_number;
  logic [15:0] confidence;

  // Sigmoid unit.
  logic [14:0] mag;
  logic x_pos;
  logic e_one;
  logic [31:0] e;
  logic [4:0] step;
  logic [49:0] rem, dsh;
  logic [16:0] quo;

  // Box arithmetic.
  logic signed [35:0] cx2, cy2, dl, dt;
  logic [33:0] sqw, sqh;
  logic [29:0] wsz, hsz;
  logic signed [52:0] lq, tq;
  logic [45:0] wsc, hsc;

  logic signed [15:0] op, x, ax;
  logic [31:0] c_now;
  logic [63:0] e_prod;
  logic [32:0] e_full;
  logic [33:0] d;
  logic [49:0] num;
  logic [15:0] sig_q;
  logic signed [25:0] cx_c, cy_c;
  logic [45:0] prod_w, prod_h;

  function automatic logic [15:0] sat_edge(input logic signed [52:0] v);
    logic signed [52:0] adj, sh;
    logic [15:0] r;
    adj = v[52] ? v + 53'sd536870911 : v;
    sh = adj >>> 29;
    if (sh > 53'sd32767) r = 16'h7FFF;
    else if (sh < -53'sd32768) r = 16'h8000;
    else r = sh[15:0];
    return r;
  endfunction

  function automatic logic [15:0] sat_size(input logic [45:0] v);
    return (v[45:44] != 2'b00) ? 16'hFFFF : v[43:28];
  endfunction

  assign op = cmd.sig_sel_best ? best_class_logit : item_r.logit;
  assign x = {op[15:dhbd_pkg::SIG_SHIFT], 1'b1, {(dhbd_pkg::SIG_SHIFT - 1){1'b0}}};
  assign ax = op[15] ? -x : x;
  assign c_now = dhbd_pkg::exp_const(step[3:0]);
  assign e_prod = e * c_now;
  assign e_full = e_one ? {1'b1, 32'd0} : {1'b0, e};
  assign d = {1'b0, e_full} + {2'b01, 32'd0};
  assign num = x_pos ? ({2'b01, 48'd0} + {17'd0, d[33:1]})
                     : ({1'b0, e_full, 16'd0} + {17'd0, d[33:1]});
  assign sig_q = quo[16] ? 16'hFFFF : quo[15:0];
  assign cx_c = $signed({2'b00, item_r.cell_x, 16'h0000})
              + $signed({9'd0, box_terms[0], 1'b0}) - 26'sd32768;
  assign cy_c = $signed({2'b00, item_r.cell_y, 16'h0000})
              + $signed({9'd0, box_terms[1], 1'b0}) - 26'sd32768;
  assign prod_w = sqw * item_r.anchor_width;
  assign prod_h = sqh * item_r.anchor_height;

  always_comb begin
    stat.needs_sig = (pos <= dhbd_pkg::POS_OBJECT);
    stat.last = item_r.last_of_cell;
    stat.obj_pass = (object_prob > object_threshold);
    stat.conf_pass = (sig_q > class_threshold);
    stat.exp_done = (step == dhbd_pkg::EXP_LAST);
    stat.div_done = (step == dhbd_pkg::DIV_LAST);
    stat.out_free = !box_valid || !box_stall;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      object_threshold <= 16'd32768;
      class_threshold <= 16'd16384;
      scale_x <= 16'd4096;
      scale_y <= 16'd4096;
    end else if (cfg_we) begin
      unique case (cfg_index)
        dhbd_pkg::CFG_OBJECT_THRESHOLD: object_threshold <= cfg_data;
        dhbd_pkg::CFG_CLASS_THRESHOLD: class_threshold <= cfg_data;
        dhbd_pkg::CFG_SCALE_X: scale_x <= cfg_data;
        dhbd_pkg::CFG_SCALE_Y: scale_y <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      element_count <= 8'd0;
    end else if (cmd.accept) begin
      if (item.last_of_cell) element_count <= 8'd0;
      else if (element_count != dhbd_pkg::POS_MAX) element_count <= element_count + 8'd1;
    end
  end

  // Argmax runs at the accept edge, so the updated best is ready for the final sigmoid.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      item_r <= item;
      pos <= element_count;
      if (element_count >= dhbd_pkg::POS_CLASS && element_count != dhbd_pkg::POS_MAX &&
          (element_count - dhbd_pkg::POS_CLASS) < dhbd_pkg::CLASS_LIMIT) begin
        if (element_count == dhbd_pkg::POS_CLASS || item.logit > best_class_logit) begin
          best_class_logit <= item.logit;
          best_class_number <= element_count - dhbd_pkg::POS_CLASS;
        end
      end
    end
    if (cmd.write_elem) begin
      if (pos == dhbd_pkg::POS_OBJECT) object_prob <= sig_q;
      else box_terms[pos[1:0]] <= sig_q;
    end
    if (cmd.write_conf) confidence <= sig_q;
  end

  // e^-|x| as a product of one constant per set bit, then a restoring division.
  always_ff @(posedge clk) begin
    if (cmd.sig_start) begin
      mag <= ax[14:0];
      x_pos <= !op[15];
      e_one <= 1'b1;
      step <= 5'd0;
    end else if (cmd.exp_step) begin
      if (mag[step[3:0]]) begin
        e_one <= 1'b0;
        e <= e_one ? c_now : e_prod[63:32];
      end
      step <= step + 5'd1;
    end else if (cmd.div_start) begin
      rem <= num;
      dsh <= {d, 16'd0};
      quo <= 17'd0;
      step <= 5'd0;
    end else if (cmd.div_step) begin
      if (rem >= dsh) begin
        rem <= rem - dsh;
        quo <= {quo[15:0], 1'b1};
      end else begin
        quo <= {quo[15:0], 1'b0};
      end
      dsh <= {1'b0, dsh[49:1]};
      step <= step + 5'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.box1) begin
      cx2 <= 36'(cx_c) <<< ({1'b0, item_r.stride_log2} + 4'd1);
      cy2 <= 36'(cy_c) <<< ({1'b0, item_r.stride_log2} + 4'd1);
      sqw <= {box_terms[2], 1'b0} * {box_terms[2], 1'b0};
      sqh <= {box_terms[3], 1'b0} * {box_terms[3], 1'b0};
    end
    if (cmd.box2) begin
      wsz <= prod_w[45:16];
      hsz <= prod_h[45:16];
    end
    if (cmd.box3) begin
      dl <= cx2 - $signed({6'd0, wsz});
      dt <= cy2 - $signed({6'd0, hsz});
    end
    if (cmd.box4) begin
      lq <= dl * $signed({1'b0, scale_x});
      tq <= dt * $signed({1'b0, scale_y});
      wsc <= wsz * scale_x;
      hsc <= hsz * scale_y;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      box_valid <= 1'b0;
    end else if (cmd.out_load) begin
      box_valid <= 1'b1;
    end else if (!box_stall) begin
      box_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      box.box_left <= sat_edge(lq);
      box.box_top <= sat_edge(tq);
      box.box_width <= sat_size(wsc);
      box.box_height <= sat_size(hsc);
      box.class_index <= best_class_number;
      box.confidence <= confidence;
    end
  end

endmodule

// ----- rtl/detection_head_box_decode.sv -----
// Box decoder for one detector grid cell per logit stream: top level.
// A box or objectness element runs 15 exponent steps and 17 divide steps.
// Class elements need no sigmoid; a box-yielding closing element runs one, then the box steps.
// Throughput is one element at a time, set by the shared sigmoid multiply and divide unit.
// Reset (rst, synchronous, high) clears the element count, the controller and the result valid.
// Configuration registers return to their defaults on reset; cell stores hold garbage until written.
`timescale 1ns / 1ps

module detection_head_box_decode (
  input  logic clk,
  input  logic rst,
  input  logic item_valid,
  output logic item_stall,
  input  dhbd_pkg::item_t item,
  output logic box_valid,
  input  logic box_stall,
  output dhbd_pkg::box_t box,
  input  logic cfg_we,
  input  logic [7:0] cfg_index,
  input  logic [15:0] cfg_data
);

  // The controller sequences each item: it takes one element, decides whether a sigmoid
  // is needed, runs the exponent and divide steps, and on a passing cell runs four box
  // arithmetic steps before loading the result register. The result register parts the
  // two sides, so a new item is taken while an earlier box waits to be taken.
  dhbd_pkg::cmd_t cmd;
  dhbd_pkg::stat_t stat;

  dhbd_ctrl u_ctrl (
    .clk(clk),
    .rst(rst),
    .item_valid(item_valid),
    .item_stall(item_stall),
    .stat(stat),
    .cmd(cmd)
  );

  // The datapath holds the cell state, the configuration registers, the sigmoid unit,
  // the box multipliers and the result register.
  dhbd_datapath u_datapath (
    .clk(clk),
    .rst(rst),
    .item(item),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .cmd(cmd),
    .stat(stat),
    .box_valid(box_valid),
    .box_stall(box_stall),
    .box(box)
  );

endmodule

// ----- tb/tb.sv -----
// Self-checking testbench for detection_head_box_decode.
// Depends on dhbd_pkg for the item, box and register index definitions.
`timescale 1ns / 1ps

module tb;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic item_valid = 1'b0;
  logic item_stall;
  dhbd_pkg::item_t item = '0;
  logic box_valid;
  logic box_stall = 1'b0;
  dhbd_pkg::box_t box;
  logic cfg_we = 1'b0;
  logic [7:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;

  detection_head_box_decode i_dut (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_stall(item_stall), .item(item),
    .box_valid(box_valid), .box_stall(box_stall), .box(box),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predictor state: a private copy of the registers and the cell stores.
  logic [15:0] obj_thr, cls_thr, sc_x, sc_y;
  logic [7:0] elem_pos;
  logic [15:0] box_sig [4];
  logic [15:0] obj_sig;
  logic signed [15:0] best_logit;
  logic [7:0] best_num;

  dhbd_pkg::box_t expected_boxes[$];
  int errors = 0;
  int boxes_seen = 0;

  // The e^-x constants in Q32, one per bit of |x| in Q8.8.
  localparam logic [31:0] EXP_Q32 [15] = '{
    32'd4278222805, 32'd4261543592, 32'd4228380001, 32'd4162825044,
    32'd4034748382, 32'd3790295336, 32'd3344923894, 32'd2605029343,
    32'd1580030169, 32'd581260640, 32'd78665070, 32'd1440802, 32'd483,
    32'd0, 32'd0};

  // Table sigmoid: the logit picks a table entry, which is evaluated at its centre.
  function automatic logic [15:0] sigmoid_q16(input logic signed [15:0] lg);
    logic [15:0] idx;
    longint x, a;
    longint unsigned e, d, r;
    idx = (lg + 16'h8000) >> dhbd_pkg::SIG_SHIFT;
    x = longint'(idx << dhbd_pkg::SIG_SHIFT) - 32768 + (1 << (dhbd_pkg::SIG_SHIFT - 1));
    a = (x < 0) ? -x : x;
    e = 64'd1 << 32;
    for (int b = 0; b < 15; b++)
      if (a[b]) e = (e * EXP_Q32[b]) >> 32;
    d = (64'd1 << 32) + e;
    if (x >= 0) r = ((64'd1 << 48) + d / 2) / d;
    else r = ((e << 16) + d / 2) / d;
    return (r > 65535) ? 16'hFFFF : r[15:0];
  endfunction

  function automatic logic signed [15:0] clamp_edge(input longint v);
    if (v > 32767) return 16'sd32767;
    if (v < -32768) return -16'sd32768;
    return v[15:0];
  endfunction

  function automatic logic [15:0] clamp_size(input longint unsigned v);
    return (v > 65535) ? 16'hFFFF : v[15:0];
  endfunction

  // Centre in Q16 network pixels: (2s - 0.5 + cell) << stride.
  function automatic longint centre_q16(input logic [15:0] s, input logic [7:0] c,
                                        input logic [2:0] sl);
    return (2 * longint'(s) - 32768 + longint'(c) * 65536) * (longint'(1) << sl);
  endfunction

  // Size in Q16 network pixels: (2s)^2 * anchor.
  function automatic longint unsigned size_q16(input logic [15:0] s,
                                              input logic [11:0] anc);
    longint unsigned t;
    t = 2 * longint'(s);
    return (t * t * anc) >> 16;
  endfunction

  // Advances the predicted cell state by one item and queues any box it yields.
  task automatic predict_box(input dhbd_pkg::item_t it);
    logic [7:0] pos;
    logic [15:0] conf;
    longint cx, cy, lq, tq;
    longint unsigned w, h;
    dhbd_pkg::box_t b;
    pos = elem_pos;
    if (pos != dhbd_pkg::POS_MAX) begin
      if (pos < dhbd_pkg::POS_OBJECT) box_sig[pos[1:0]] = sigmoid_q16(it.logit);
      else if (pos == dhbd_pkg::POS_OBJECT) obj_sig = sigmoid_q16(it.logit);
      else if (pos - dhbd_pkg::POS_CLASS < dhbd_pkg::CLASS_LIMIT) begin
        if (pos == dhbd_pkg::POS_CLASS || it.logit > best_logit) begin
          best_logit = it.logit;
          best_num = pos - dhbd_pkg::POS_CLASS;
        end
      end
      elem_pos = pos + 8'd1;
    end
    if (!it.last_of_cell) return;
    elem_pos = '0;
    if (pos < dhbd_pkg::POS_CLASS || obj_sig <= obj_thr) return;
    conf = sigmoid_q16(best_logit);
    if (conf <= cls_thr) return;
    cx = centre_q16(box_sig[0], it.cell_x, it.stride_log2);
    cy = centre_q16(box_sig[1], it.cell_y, it.stride_log2);
    w = size_q16(box_sig[2], it.anchor_width);
    h = size_q16(box_sig[3], it.anchor_height);
    lq = (2 * cx - longint'(w)) * longint'(sc_x);
    tq = (2 * cy - longint'(h)) * longint'(sc_y);
    b.box_left = clamp_edge(lq / (longint'(1) << 29));
    b.box_top = clamp_edge(tq / (longint'(1) << 29));
    b.box_width = clamp_size((w * sc_x) >> 28);
    b.box_height = clamp_size((h * sc_y) >> 28);
    b.class_index = best_num;
    b.confidence = conf;
    expected_boxes = {expected_boxes, b};
  endtask

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("MISMATCH box %0d %s: got %0d expected %0d", boxes_seen, what, got, want);
    errors++;
  endtask

  // Every accepted box is compared field by field against the oldest expectation.
  always @(posedge clk) begin
    dhbd_pkg::box_t w;
    if (!rst && box_valid && !box_stall) begin
      if (expected_boxes.size() == 0) begin
        report_mismatch("unexpected box, class", box.class_index, -1);
      end else begin
        w = expected_boxes.pop_front();
        if (box.box_left !== w.box_left) report_mismatch("left", box.box_left, w.box_left);
        if (box.box_top !== w.box_top) report_mismatch("top", box.box_top, w.box_top);
        if (box.box_width !== w.box_width)
          report_mismatch("width", box.box_width, w.box_width);
        if (box.box_height !== w.box_height)
          report_mismatch("height", box.box_height, w.box_height);
        if (box.class_index !== w.class_index)
          report_mismatch("class", box.class_index, w.class_index);
        if (box.confidence !== w.confidence)
          report_mismatch("confidence", box.confidence, w.confidence);
      end
      boxes_seen++;
    end
  end

  // The receiver stalls in one of several modes that change now and then.
  int stall_mode = 0;
  always @(negedge clk) begin
    if ($urandom_range(0, 63) == 0) stall_mode = $urandom_range(0, 3);
    case (stall_mode)
      0: box_stall <= 1'b0;
      1: box_stall <= ($urandom_range(0, 3) == 0);
      2: box_stall <= ($urandom_range(0, 1) == 0);
      default: box_stall <= ($urandom_range(0, 7) != 0);
    endcase
  end

  // Bursts of items, some separated by random gaps.
  int burst_left = 0;

  // Presents one item and holds it until it is taken. Valid stays high after the
  // accept edge only until the next item is presented at the same falling edge;
  // any wait drops it first.
  task automatic send_item(input dhbd_pkg::item_t it);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      if ($urandom_range(0, 2) == 0) begin
        item_valid <= 1'b0;
        repeat ($urandom_range(1, 60)) @(negedge clk);
      end
    end
    burst_left--;
    item <= it;
    item_valid <= 1'b1;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    predict_box(it);
    @(negedge clk);
  endtask

  // Waits for all boxes, then for the longest latency of a closing item.
  task automatic drain_boxes();
    item_valid <= 1'b0;
    while (expected_boxes.size() != 0) @(negedge clk);
    repeat (60) @(negedge clk);
  endtask

  task automatic write_reg(input logic [7:0] idx, input logic [15:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
    case (idx)
      dhbd_pkg::CFG_OBJECT_THRESHOLD: obj_thr = val;
      dhbd_pkg::CFG_CLASS_THRESHOLD: cls_thr = val;
      dhbd_pkg::CFG_SCALE_X: sc_x = val;
      default: sc_y = val;
    endcase
  endtask

  function automatic dhbd_pkg::item_t make_item(input logic signed [15:0] lg, input bit last);
    dhbd_pkg::item_t it;
    it.logit = lg;
    it.cell_x = 8'($urandom_range(0, 255));
    it.cell_y = 8'($urandom_range(0, 255));
    it.stride_log2 = 3'($urandom_range(0, 7));
    it.anchor_width = 12'($urandom_range(0, 4095));
    it.anchor_height = 12'($urandom_range(0, 4095));
    it.last_of_cell = last;
    return it;
  endfunction

  // Sends one whole cell: box terms, objectness and n_cls class logits.
  // Most cells have strong objectness so that they pass the objectness threshold in most phases.
  task automatic send_cell(input int n_cls);
    int total;
    logic signed [15:0] lg;
    total = 5 + n_cls;
    for (int k = 0; k < total; k++) begin
      if (k == 4 && $urandom_range(0, 3) != 0) lg = 16'($urandom_range(256, 32767));
      else if ($urandom_range(0, 7) == 0) lg = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
      else if ($urandom_range(0, 1)) lg = 16'($urandom());
      else lg = $signed(16'($urandom_range(0, 2047))) - 16'sd1024;
      send_item(make_item(lg, k == total - 1));
    end
  endtask

  // Directed cells: each row is a logit and a last flag, with one geometry
  // fixed so that the boxes at the extremes can be read off directly.
  typedef struct {
    logic signed [15:0] logit;
    bit last;
  } row_t;

  row_t directed [24] = '{
    // Early end: closes after four elements, no box.
    '{16'sh7FFF, 0}, '{16'sh8000, 0}, '{16'sh7FFF, 0}, '{16'sh8000, 1},
    // Full cell with extreme box terms and a tie in the class scores.
    '{16'sh7FFF, 0}, '{16'sh7FFF, 0}, '{16'sh7FFF, 0}, '{16'sh7FFF, 0},
    '{16'sh7FFF, 0}, '{16'sh0100, 0}, '{16'sh0400, 0}, '{16'sh0400, 1},
    // Objectness at the bottom: rejected.
    '{16'sh8000, 0}, '{16'sh8000, 0}, '{16'sh8000, 0}, '{16'sh8000, 0},
    '{16'sh8000, 0}, '{16'sh7FFF, 1},
    // Weak best class: rejected at the class threshold.
    '{16'sh0000, 0}, '{16'sh0000, 0}, '{16'sh0000, 0}, '{16'sh0000, 0},
    '{16'sh7FFF, 0}, '{16'sh8000, 1}
  };

  initial begin
    dhbd_pkg::item_t it;
    obj_thr = 16'd32768;
    cls_thr = 16'd16384;
    sc_x = 16'd4096;
    sc_y = 16'd4096;
    elem_pos = '0;
    foreach (box_sig[i]) box_sig[i] = '0;
    obj_sig = '0;
    best_logit = '0;
    best_num = '0;
    repeat (3) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed part with the reset register values.
    foreach (directed[i]) begin
      it = make_item(directed[i].logit, directed[i].last);
      it.cell_x = 8'hFF;
      it.cell_y = 8'h00;
      it.stride_log2 = 3'd7;
      it.anchor_width = 12'hFFF;
      it.anchor_height = 12'h000;
      send_item(it);
    end
    drain_boxes();

    // Random phases, each under its own register setting, extremes included.
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin
          write_reg(dhbd_pkg::CFG_OBJECT_THRESHOLD, 16'd0);
          write_reg(dhbd_pkg::CFG_CLASS_THRESHOLD, 16'd0);
          write_reg(dhbd_pkg::CFG_SCALE_X, 16'hFFFF);
          write_reg(dhbd_pkg::CFG_SCALE_Y, 16'hFFFF);
        end
        1: begin
          write_reg(dhbd_pkg::CFG_OBJECT_THRESHOLD, 16'hFFFF);
          write_reg(dhbd_pkg::CFG_CLASS_THRESHOLD, 16'hFFFF);
          write_reg(dhbd_pkg::CFG_SCALE_X, 16'd0);
          write_reg(dhbd_pkg::CFG_SCALE_Y, 16'd0);
        end
        default: begin
          write_reg(dhbd_pkg::CFG_OBJECT_THRESHOLD, 16'($urandom_range(0, 40000)));
          write_reg(dhbd_pkg::CFG_CLASS_THRESHOLD, 16'($urandom_range(0, 40000)));
          write_reg(dhbd_pkg::CFG_SCALE_X, 16'($urandom()));
          write_reg(dhbd_pkg::CFG_SCALE_Y, 16'($urandom_range(1024, 8192)));
        end
      endcase
      for (int n = 0; n < 85; ) begin
        int kind, nc;
        kind = $urandom_range(0, 19);
        if (kind == 0) begin
          // Noise: a short broken cell.
          nc = $urandom_range(1, 5);
          for (int k = 0; k < nc; k++) send_item(make_item(16'($urandom()), k == nc - 1));
        end else if (kind == 1 && ph == 3) begin
          // A long cell holds at least the class count of class logits and may run past the element limit.
          nc = $urandom_range(dhbd_pkg::CLASS_COUNT, 300);
          send_cell(nc);
        end else begin
          nc = $urandom_range(1, 6);
          send_cell(nc);
        end
        n += nc + 5;
        // Now and then the sender waits until every box has come back.
        if ($urandom_range(0, 15) == 0 && expected_boxes.size() != 0) begin
          item_valid <= 1'b0;
          while (expected_boxes.size() != 0) @(negedge clk);
        end
      end
      drain_boxes();
    end

    if (errors == 0) begin
      $display("** detection_head_box_decode: PASSED **");
    end else begin
      $display("** detection_head_box_decode: FAILED **");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("** detection_head_box_decode: FAILED **");
    $finish;
  end
endmodule
